// File: rtl/tct_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tct_pkg
// Shared types and constants of the two-level write-back cache tag model.
// ----------------------------------------------------------------------------
package tct_pkg;

    localparam int BYTE_ADDR_W   = 48;
    localparam int LINE_SHIFT    = 6;
    localparam int STAMP_W       = 32;
    localparam int MWB_W         = 2;

    localparam int DEF_FIRST_SETS   = 64;
    localparam int DEF_FIRST_WAYS   = 8;
    localparam int DEF_SECOND_SETS  = 512;
    localparam int DEF_SECOND_WAYS  = 8;
    localparam int DEF_ADDRESS_BITS = 48;

    typedef struct packed {
        logic [BYTE_ADDR_W-1:0] byte_address;
        logic                   write_access;
    } t_req;

    typedef struct packed {
        logic             l1_hit;
        logic             l2_hit;
        logic             l2_miss;
        logic             l1_dirty_evict;
        logic [MWB_W-1:0] memory_writebacks;
    } t_rsp;

endpackage

// File: rtl/tct_way_sel.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tct_way_sel
// Tag compare and replacement choice over the ways of one set row.
// ----------------------------------------------------------------------------
module tct_way_sel
    import tct_pkg::*;
#(
    parameter int WAYS  = DEF_FIRST_WAYS,
    parameter int TAG_W = 36,
    parameter int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1
) (
    input  logic [TAG_W-1:0]              i_tag,
    input  logic [WAYS-1:0][TAG_W-1:0]    i_tags,
    input  logic [WAYS-1:0]               i_vld,
    input  logic [WAYS-1:0][STAMP_W-1:0]  i_stamps,
    output logic                          o_hit,
    output logic [WAY_W-1:0]              o_hit_way,
    output logic [WAY_W-1:0]              o_vic_way
);

    logic               found_inv;
    logic [WAY_W-1:0]   inv_way;
    logic [WAY_W-1:0]   old_way;
    logic [STAMP_W-1:0] old_stamp;

    always_comb begin
        o_hit     = 1'b0;
        o_hit_way = '0;
        for (int w = 0; w < WAYS; w++) begin
            if (!o_hit && i_vld[w] && (i_tags[w] == i_tag)) begin
                o_hit     = 1'b1;
                o_hit_way = WAY_W'(w);
            end
        end
    end

    always_comb begin
        found_inv = 1'b0;
        inv_way   = '0;
        old_way   = '0;
        old_stamp = i_stamps[0];
        for (int w = 0; w < WAYS; w++) begin
            if (!found_inv && !i_vld[w]) begin
                found_inv = 1'b1;
                inv_way   = WAY_W'(w);
            end
            if (i_stamps[w] < old_stamp) begin
                old_stamp = i_stamps[w];
                old_way   = WAY_W'(w);
            end
        end
        o_vic_way = found_inv ? inv_way : old_way;
    end

endmodule

// File: rtl/two_level_writeback_cache_tags.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_level_writeback_cache_tags
// Tag-only two-level write-back cache with per-set LRU stamps; each access
// reports hit, eviction and memory writeback flags.
// ----------------------------------------------------------------------------
// channel   direction  handshake              payload
// request   in         start & !busy          i_req (t_req)
// result    out        o_done, one cycle      o_rsp (t_rsp)
//
// an L1 hit or a miss is resolved in ST_LOOK; a miss with a dirty L1 victim also passes
// ST_VREAD and ST_VWB, as the L2 set memory has a single read port
// after reset a clearing pass over max(FIRST_SETS, SECOND_SETS) rows zeroes
// both set memories while busy is high
// the result strobe is registered and cannot be stalled
// set counts are powers of two
// ----------------------------------------------------------------------------
module two_level_writeback_cache_tags
    import tct_pkg::*;
#(
    parameter int FIRST_SETS   = DEF_FIRST_SETS,
    parameter int FIRST_WAYS   = DEF_FIRST_WAYS,
    parameter int SECOND_SETS  = DEF_SECOND_SETS,
    parameter int SECOND_WAYS  = DEF_SECOND_WAYS,
    parameter int ADDRESS_BITS = DEF_ADDRESS_BITS
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_req i_req,
    output logic busy,
    output logic o_done,
    output t_rsp o_rsp
);

    localparam int AB   = (ADDRESS_BITS < BYTE_ADDR_W) ? ADDRESS_BITS : BYTE_ADDR_W;
    localparam int LB   = AB - LINE_SHIFT;
    localparam int S1B  = $clog2(FIRST_SETS);
    localparam int S2B  = $clog2(SECOND_SETS);
    localparam int T1W  = LB - S1B;
    localparam int T2W  = LB - S2B;
    localparam int W1B  = (FIRST_WAYS > 1) ? $clog2(FIRST_WAYS) : 1;
    localparam int W2B  = (SECOND_WAYS > 1) ? $clog2(SECOND_WAYS) : 1;
    localparam int MAXS = (FIRST_SETS > SECOND_SETS) ? FIRST_SETS : SECOND_SETS;
    localparam int CB   = $clog2(MAXS);

    typedef struct packed {
        logic [FIRST_WAYS-1:0][T1W-1:0]     tag;
        logic [FIRST_WAYS-1:0]              vld;
        logic [FIRST_WAYS-1:0]              drt;
        logic [FIRST_WAYS-1:0][STAMP_W-1:0] stamp;
        logic [STAMP_W-1:0]                 ctr;
    } t_row1;

    typedef struct packed {
        logic [SECOND_WAYS-1:0][T2W-1:0]     tag;
        logic [SECOND_WAYS-1:0]              vld;
        logic [SECOND_WAYS-1:0]              drt;
        logic [SECOND_WAYS-1:0][STAMP_W-1:0] stamp;
        logic [STAMP_W-1:0]                  ctr;
    } t_row2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK,
        ST_VREAD,
        ST_VWB
    } t_state;

    t_row1 l1_mem [FIRST_SETS];
    t_row2 l2_mem [SECOND_SETS];

    t_state           r_state, n_state;
    logic [CB-1:0]    r_clr;
    logic [LB-1:0]    r_line;
    logic             r_wr;
    t_row1            r_l1_q;
    t_row2            r_l2_q;
    logic             r_l2h, n_l2h;
    logic             r_l2m, n_l2m;
    logic [MWB_W-1:0] r_mwb, n_mwb;
    logic [S2B-1:0]   r_vs, n_vs;
    logic [T2W-1:0]   r_vt, n_vt;
    logic             r_done, n_done;
    t_rsp             r_rsp, n_rsp;

    logic             accept;
    logic [LB-1:0]    in_line;
    logic [S1B-1:0]   s1;
    logic [T1W-1:0]   t1;
    logic [S2B-1:0]   s2;
    logic [T2W-1:0]   t2;
    logic [LB-1:0]    vline;

    logic             l1_re, l1_we;
    logic [S1B-1:0]   l1_ra, l1_wa;
    t_row1            l1_wd;
    logic             l2_re, l2_we;
    logic [S2B-1:0]   l2_ra, l2_wa;
    t_row2            l2_wd;

    logic             l1_hit;
    logic [W1B-1:0]   l1_hw, l1_vw;
    logic             l2_hit;
    logic [W2B-1:0]   l2_hw, l2_vw;
    logic [T2W-1:0]   l2_key;
    logic [STAMP_W-1:0] l1_nc, l2_nc;

    assign accept  = start && !busy;
    assign in_line = i_req.byte_address[AB-1:LINE_SHIFT];
    assign s1      = r_line[S1B-1:0];
    assign t1      = r_line[LB-1:S1B];
    assign s2      = r_line[S2B-1:0];
    assign t2      = r_line[LB-1:S2B];
    assign vline   = {r_l1_q.tag[l1_vw], s1};
    assign l2_key  = (r_state == ST_VWB) ? r_vt : t2;
    assign l1_nc   = r_l1_q.ctr + STAMP_W'(1);
    assign l2_nc   = r_l2_q.ctr + STAMP_W'(1);

    tct_way_sel #(
        .WAYS  (FIRST_WAYS),
        .TAG_W (T1W),
        .WAY_W (W1B)
    ) u_l1_sel (
        .i_tag     (t1),
        .i_tags    (r_l1_q.tag),
        .i_vld     (r_l1_q.vld),
        .i_stamps  (r_l1_q.stamp),
        .o_hit     (l1_hit),
        .o_hit_way (l1_hw),
        .o_vic_way (l1_vw)
    );

    tct_way_sel #(
        .WAYS  (SECOND_WAYS),
        .TAG_W (T2W),
        .WAY_W (W2B)
    ) u_l2_sel (
        .i_tag     (l2_key),
        .i_tags    (r_l2_q.tag),
        .i_vld     (r_l2_q.vld),
        .i_stamps  (r_l2_q.stamp),
        .o_hit     (l2_hit),
        .o_hit_way (l2_hw),
        .o_vic_way (l2_vw)
    );

    always_comb begin
        n_state = r_state;
        n_l2h   = r_l2h;
        n_l2m   = r_l2m;
        n_mwb   = r_mwb;
        n_vs    = r_vs;
        n_vt    = r_vt;
        n_done  = 1'b0;
        n_rsp   = r_rsp;
        l1_re   = 1'b0;
        l1_ra   = in_line[S1B-1:0];
        l1_we   = 1'b0;
        l1_wa   = s1;
        l1_wd   = r_l1_q;
        l2_re   = 1'b0;
        l2_ra   = in_line[S2B-1:0];
        l2_we   = 1'b0;
        l2_wa   = s2;
        l2_wd   = r_l2_q;
        case (r_state)
            ST_CLEAR: begin
                l1_we = 1'b1;
                l1_wa = r_clr[S1B-1:0];
                l1_wd = '0;
                l2_we = 1'b1;
                l2_wa = r_clr[S2B-1:0];
                l2_wd = '0;
                if (r_clr == CB'(MAXS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    l1_re   = 1'b1;
                    l2_re   = 1'b1;
                    n_state = ST_LOOK;
                end
            end
            ST_LOOK: begin
                l1_we = 1'b1;
                if (l1_hit) begin
                    l1_wd.ctr          = l1_nc;
                    l1_wd.stamp[l1_hw] = l1_nc;
                    l1_wd.drt[l1_hw]   = r_l1_q.drt[l1_hw] | r_wr;
                    n_rsp   = '{l1_hit: 1'b1, default: '0};
                    n_done  = 1'b1;
                    n_state = ST_IDLE;
                end else begin
                    l2_we = 1'b1;
                    l2_wd.ctr = l2_nc;
                    if (l2_hit) begin
                        l2_wd.stamp[l2_hw] = l2_nc;
                        n_mwb = '0;
                    end else begin
                        l2_wd.stamp[l2_vw] = l2_nc;
                        l2_wd.tag[l2_vw]   = t2;
                        l2_wd.vld[l2_vw]   = 1'b1;
                        l2_wd.drt[l2_vw]   = 1'b0;
                        n_mwb = {1'b0, r_l2_q.vld[l2_vw] & r_l2_q.drt[l2_vw]};
                    end
                    n_l2h = l2_hit;
                    n_l2m = !l2_hit;
                    l1_wd.ctr          = l1_nc;
                    l1_wd.stamp[l1_vw] = l1_nc;
                    l1_wd.tag[l1_vw]   = t1;
                    l1_wd.vld[l1_vw]   = 1'b1;
                    l1_wd.drt[l1_vw]   = r_wr;
                    n_vs = vline[S2B-1:0];
                    n_vt = vline[LB-1:S2B];
                    if (r_l1_q.vld[l1_vw] && r_l1_q.drt[l1_vw]) begin
                        n_state = ST_VREAD;
                    end else begin
                        n_rsp   = '{l1_hit: 1'b0, l2_hit: l2_hit, l2_miss: !l2_hit,
                                    l1_dirty_evict: 1'b0, memory_writebacks: n_mwb};
                        n_done  = 1'b1;
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_VREAD: begin
                l2_re   = 1'b1;
                l2_ra   = r_vs;
                n_state = ST_VWB;
            end
            ST_VWB: begin
                l2_we = 1'b1;
                l2_wa = r_vs;
                if (l2_hit) begin
                    l2_wd.drt[l2_hw] = 1'b1;
                end else begin
                    l2_wd.ctr          = l2_nc;
                    l2_wd.stamp[l2_vw] = l2_nc;
                    l2_wd.tag[l2_vw]   = r_vt;
                    l2_wd.vld[l2_vw]   = 1'b1;
                    l2_wd.drt[l2_vw]   = 1'b1;
                    n_mwb = r_mwb + MWB_W'(r_l2_q.vld[l2_vw] & r_l2_q.drt[l2_vw]);
                end
                n_rsp   = '{l1_hit: 1'b0, l2_hit: r_l2h, l2_miss: r_l2m,
                            l1_dirty_evict: 1'b1, memory_writebacks: n_mwb};
                n_done  = 1'b1;
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (l1_we) begin
            l1_mem[l1_wa] <= l1_wd;
        end
        if (l1_re) begin
            r_l1_q <= l1_mem[l1_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (l2_we) begin
            l2_mem[l2_wa] <= l2_wd;
        end
        if (l2_re) begin
            r_l2_q <= l2_mem[l2_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + CB'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_line <= in_line;
            r_wr   <= i_req.write_access;
        end
        r_l2h <= n_l2h;
        r_l2m <= n_l2m;
        r_mwb <= n_mwb;
        r_vs  <= n_vs;
        r_vt  <= n_vt;
        r_rsp <= n_rsp;
    end

    assign busy   = (r_state != ST_IDLE);
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

endmodule
